// ----- rtl/core/wfs_pkg.sv -----
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared constants and types of the waypoint follow step core.
// ----------------------------------------------------------------------------
package wfs_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned SqrtIts = 33;
  localparam int unsigned DivIts  = 64;
  localparam int unsigned IterW   = 7;
  localparam logic [23:0] SpeedRst = 24'd65536;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MOVING  = 3'd3,
    ST_REACHED = 3'd4
  } status_e;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    mul1;
    logic    mul2;
    logic    sum;
    logic    sqrt_init;
    logic    sqrt_step;
    logic    prod;
    logic    div_step;
    logic    move;
    logic    reach;
    logic    out_load;
    status_e out_status;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic far;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/wfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wfs_ctrl
// Sequencer: decodes a beat and steps the datapath through the move math.
// ----------------------------------------------------------------------------
module wfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wfs_pkg::sts_t sts_i,
  output wfs_pkg::cmd_t cmd_o
);

  localparam int unsigned IterW = wfs_pkg::IterW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL1, S_MUL2, S_SUM, S_CHK, S_SQRT, S_PROD, S_DIV, S_UPD, S_OUT
  } state_e;

  state_e                        state_q;
  logic [wfs_pkg::IterW-1:0]     cnt_q;
  wfs_pkg::status_e              status_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.out_status = status_q;
    case (state_q)
      S_IDLE: cmd_o.load_in = in_valid_i;
      S_DEC:  cmd_o.push = !sts_i.is_tick && !sts_i.full;
      S_MUL1: cmd_o.mul1 = 1'b1;
      S_MUL2: cmd_o.mul2 = 1'b1;
      S_SUM:  cmd_o.sum = 1'b1;
      S_CHK: begin
        cmd_o.sqrt_init = sts_i.far;
        cmd_o.reach     = !sts_i.far;
      end
      S_SQRT: cmd_o.sqrt_step = 1'b1;
      S_PROD: cmd_o.prod = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_UPD:  cmd_o.move = 1'b1;
      S_OUT:  cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      status_q <= wfs_pkg::ST_PUSHED;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DEC;
        S_DEC: begin
          if (!sts_i.is_tick) begin
            status_q <= sts_i.full ? wfs_pkg::ST_DROPPED : wfs_pkg::ST_PUSHED;
            state_q  <= S_OUT;
          end else if (sts_i.empty) begin
            status_q <= wfs_pkg::ST_EMPTY;
            state_q  <= S_OUT;
          end else begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_SUM;
        S_SUM:  state_q <= S_CHK;
        S_CHK: begin
          cnt_q <= '0;
          if (sts_i.far) begin
            state_q <= S_SQRT;
          end else begin
            status_q <= wfs_pkg::ST_REACHED;
            state_q  <= S_OUT;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IterW'(wfs_pkg::SqrtIts - 1)) state_q <= S_PROD;
        end
        S_PROD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IterW'(wfs_pkg::DivIts - 1)) state_q <= S_UPD;
        end
        S_UPD: begin
          status_q <= wfs_pkg::ST_MOVING;
          state_q  <= S_OUT;
        end
        S_OUT: if (!sts_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/wfs_dp.sv -----
// ----------------------------------------------------------------------------
// wfs_dp
// Datapath: position, waypoint queue, multipliers, square root and dividers.
// ----------------------------------------------------------------------------
module wfs_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wfs_pkg::cmd_t cmd_i,
  output wfs_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_wdata_i,
  input  logic          func_i,
  input  logic [31:0]   waypoint_x_i,
  input  logic [31:0]   waypoint_y_i,
  input  logic [23:0]   elapsed_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   pos_x_o,
  output logic [31:0]   pos_y_o,
  output logic [31:0]   target_x_o,
  output logic [31:0]   target_y_o,
  output logic [2:0]    status_o,
  output logic [4:0]    queued_o
);

  localparam int unsigned IdxW = wfs_pkg::IdxW;
  localparam int unsigned CntW = wfs_pkg::CntW;

  logic [63:0]      mem_q [wfs_pkg::Depth];
  logic [63:0]      rd_q;
  logic [IdxW-1:0]  head_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW:0]    tail_sum;
  logic [IdxW-1:0]  tail;

  logic [23:0] speed_q;
  logic        func_q;
  logic [31:0] wx_q, wy_q;
  logic [23:0] el_q;
  logic [31:0] px_q, py_q;
  logic [31:0] tx_q, ty_q;
  logic [31:0] travel_q, ax_q, ay_q;
  logic        nx_q, ny_q;
  logic [63:0] a2_q, b2_q, t2_q;
  logic [64:0] s_q;
  logic [65:0] sh_q;
  logic [35:0] srem_q;
  logic [32:0] root_q;
  logic [32:0] len;
  logic [63:0] qx_q, qy_q;
  logic [32:0] rx_q, ry_q;
  logic [32:0] dxs, dys;
  logic [35:0] srem_n, strial;
  logic [33:0] rx_n, ry_n;
  logic [47:0] tprod;

  logic        out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[tail] <= {wx_q, wy_q};
    rd_q <= mem_q[head_q];
  end

  always_comb begin
    tail_sum = {1'b0, CntW'(head_q)} + {1'b0, cnt_q};
    if (tail_sum >= (CntW + 1)'(wfs_pkg::Depth)) begin
      tail_sum = tail_sum - (CntW + 1)'(wfs_pkg::Depth);
    end
    tail = tail_sum[IdxW-1:0];
  end

  assign dxs    = {rd_q[63], rd_q[63:32]} - {px_q[31], px_q};
  assign dys    = {rd_q[31], rd_q[31:0]} - {py_q[31], py_q};
  assign tprod  = el_q * speed_q;
  assign srem_n = {srem_q[33:0], sh_q[65:64]};
  assign strial = {1'b0, root_q, 2'b01};
  assign len    = (root_q == '0) ? 33'd1 : root_q;
  assign rx_n   = {rx_q, qx_q[63]};
  assign ry_n   = {ry_q, qy_q[63]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      wx_q   <= waypoint_x_i;
      wy_q   <= waypoint_y_i;
      el_q   <= elapsed_i;
    end
    if (cmd_i.mul1) begin
      travel_q <= tprod[47:16];
      tx_q     <= rd_q[63:32];
      ty_q     <= rd_q[31:0];
      nx_q     <= dxs[32];
      ny_q     <= dys[32];
      ax_q     <= dxs[32] ? 32'(-dxs) : dxs[31:0];
      ay_q     <= dys[32] ? 32'(-dys) : dys[31:0];
    end
    if (cmd_i.mul2) begin
      a2_q <= ax_q * ax_q;
      b2_q <= ay_q * ay_q;
      t2_q <= travel_q * travel_q;
    end
    if (cmd_i.sum) s_q <= {1'b0, a2_q} + {1'b0, b2_q};
    if (cmd_i.sqrt_init) begin
      sh_q   <= {1'b0, s_q};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sh_q <= {sh_q[63:0], 2'b00};
      if (srem_n >= strial) begin
        srem_q <= srem_n - strial;
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        root_q <= {root_q[31:0], 1'b0};
      end
    end
    if (cmd_i.prod) begin
      qx_q <= travel_q * ax_q;
      qy_q <= travel_q * ay_q;
      rx_q <= '0;
      ry_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rx_n >= {1'b0, len}) begin
        rx_q <= 33'(rx_n - {1'b0, len});
        qx_q <= {qx_q[62:0], 1'b1};
      end else begin
        rx_q <= rx_n[32:0];
        qx_q <= {qx_q[62:0], 1'b0};
      end
      if (ry_n >= {1'b0, len}) begin
        ry_q <= 33'(ry_n - {1'b0, len});
        qy_q <= {qy_q[62:0], 1'b1};
      end else begin
        ry_q <= ry_n[32:0];
        qy_q <= {qy_q[62:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      pos_x_o  <= px_q;
      pos_y_o  <= py_q;
      if (cmd_i.out_status == wfs_pkg::ST_MOVING || cmd_i.out_status == wfs_pkg::ST_REACHED)
      begin
        target_x_o <= tx_q;
        target_y_o <= ty_q;
      end else begin
        target_x_o <= '0;
        target_y_o <= '0;
      end
      status_o <= cmd_i.out_status;
      queued_o <= 5'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= wfs_pkg::SpeedRst;
      px_q        <= '0;
      py_q        <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) speed_q <= cfg_wdata_i;
      if (cmd_i.push) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.move) begin
        px_q <= nx_q ? px_q - qx_q[31:0] : px_q + qx_q[31:0];
        py_q <= ny_q ? py_q - qy_q[31:0] : py_q + qy_q[31:0];
      end
      if (cmd_i.reach) begin
        px_q   <= tx_q;
        py_q   <= ty_q;
        cnt_q  <= cnt_q - 1'b1;
        head_q <= (head_q == IdxW'(wfs_pkg::Depth - 1)) ? '0 : head_q + 1'b1;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sts_o.is_tick = func_q;
  assign sts_o.full    = (cnt_q == CntW'(wfs_pkg::Depth));
  assign sts_o.empty   = (cnt_q == '0);
  assign sts_o.far     = s_q > {1'b0, t2_q};
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(wfs_pkg::Depth)) else $error("queue count overflow");
  a_reach_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reach |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.out_load && out_valid_q && out_stall_i)) else $error("result overwritten");

endmodule

// ----- rtl/core/waypoint_follow_step_core.sv -----
// ----------------------------------------------------------------------------
// waypoint_follow_step_core
// Constant speed waypoint follower, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o, one beat is a push (func_i = 0,
// waypoint_x_i/waypoint_y_i) or a tick (func_i = 1, elapsed_i).
// Output channel: out_valid_o / out_stall_i, one result beat per input beat.
// Speed is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the core is idle, which the core does not enforce. A push,
// dropped push or empty tick goes from decode to output. A reaching tick
// runs multiply, sum and check; a moving tick then runs a 33 step square
// root and two 64 step dividers in parallel, one bit per cycle. One beat
// is worked on at a time; the next beat is taken once the result sits in
// the output register. Reset clears position, queue pointers and output
// valid; speed resets to 1.0. A stalled result holds; the core then waits
// with in_stall_o high after finishing the next beat.
// ----------------------------------------------------------------------------
module waypoint_follow_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] waypoint_x_i,
  input  logic [31:0] waypoint_y_i,
  input  logic [23:0] elapsed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] target_x_o,
  output logic [31:0] target_y_o,
  output logic [2:0]  status_o,
  output logic [4:0]  queued_o
);

  wfs_pkg::cmd_t cmd;
  wfs_pkg::sts_t sts;

  wfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wfs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .waypoint_x_i (waypoint_x_i),
    .waypoint_y_i (waypoint_y_i),
    .elapsed_i    (elapsed_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .target_x_o   (target_x_o),
    .target_y_o   (target_y_o),
    .status_o     (status_o),
    .queued_o     (queued_o)
  );

endmodule
